// File: rtl/hfe_c2f_pkg.sv
// Shared types, constants and helper functions for the cell stream to flux gap converter.
`timescale 1ns / 1ps
`default_nettype none
package hfe_c2f_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_CELL_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V3_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT = 2'd2;

  localparam logic [7:0] START_TICKS_RST = 8'd48;
  localparam logic [15:0] PULSE_LIMIT_RST = 16'hffff;

  localparam logic [7:0] OPC_NOP = 8'h0f;
  localparam logic [7:0] OPC_INDEX = 8'h8f;
  localparam logic [7:0] OPC_BITRATE = 8'h4f;
  localparam logic [7:0] OPC_SKIPBITS = 8'hcf;
  localparam logic [7:0] OPC_RAND = 8'h2f;
  localparam logic [3:0] OPC_NIBBLE = 4'hf;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [31:0] LCG_SEED = 32'h12345678;

  localparam logic [13:0] GAP_CAP = 14'd11985;
  localparam logic [13:0] CHUNK = 14'd255;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] first;
    logic [7:0] dur;
    logic       run;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  pulse_gap;
    logic        run_final;
    logic        track_status;
    logic [15:0] pulse_total;
    logic        overflow_error;
  } res_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // Two thirds of the argument, rounded down, via a reciprocal multiply; never below one.
  function automatic logic [7:0] rate_ticks(input logic [7:0] arg);
    logic [8:0]  twice;
    logic [18:0] prod;
    logic [7:0]  q;
    twice = {arg, 1'b0};
    prod = 19'(twice) * 19'd683;
    q = prod[18:11];
    return (q == 8'd0) ? 8'd1 : q;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hfe_cell_stream_to_flux_gaps.sv
// Top level of the track bit-cell stream to flux gap converter.
//
// Track bytes enter on a queue-style input: a request is taken when push is high and full
// is low. Each byte carries eight bit cells, least significant first; track_last marks the
// final byte of a track. Results leave on a queue-style output: the oldest result is shown
// while empty is low and is removed when pop is high. Each request gives zero or more pulse
// results, plus an end-of-track status result after a final byte; run_final marks the last
// result of a request.
// A decoder takes one byte per cycle while full is low, into a four-entry command queue;
// an opcode or argument byte that starts no cell run queues no command unless it ends a
// track. The cell engine fetches a command, walks its bit cells, splits a gap above 255
// ticks into pulse values of 255 ticks and a remainder, gives a status result after a
// track's final byte and then releases the held result.
// When pop is held low the four-entry result queue fills, the cell engine waits, then the
// command queue fills and full rises; nothing is dropped.
// Reset clears both queues, the opcode state, gap, pulse count and error flag, loads the
// registers with their defaults and the random generator with its seed. A new start cell
// duration takes effect at the next track start.
`timescale 1ns / 1ps
`default_nettype none
module hfe_cell_stream_to_flux_gaps import hfe_c2f_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            cell_byte,
  input  wire logic                  track_last,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 pulse_gap,
  output logic                       run_final,
  output logic                       track_status,
  output logic [15:0]                pulse_total,
  output logic                       overflow_error,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]  start_cell_ticks;
  logic        v3_mode;
  logic [15:0] pulse_limit;

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  res_t res_in;
  res_t res_out;
  logic res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cell_ticks <= START_TICKS_RST;
      v3_mode <= 1'b0;
      pulse_limit <= PULSE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_CELL_TICKS: start_cell_ticks <= cfg_data[7:0];
        REG_V3_MODE: v3_mode <= cfg_data[0];
        REG_PULSE_LIMIT: pulse_limit <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  hfe_c2f_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .cell_byte        (cell_byte),
    .track_last       (track_last),
    .start_cell_ticks (start_cell_ticks),
    .v3_mode          (v3_mode),
    .cmd_push         (cmd_push),
    .cmd              (cmd_in)
  );

  hfe_c2f_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  hfe_c2f_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!cmd_empty),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .pulse_limit (pulse_limit),
    .res_push    (res_push),
    .res_data    (res_in),
    .res_full    (res_full)
  );

  hfe_c2f_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_out),
    .empty     (empty)
  );

  assign pulse_gap = res_out.pulse_gap;
  assign run_final = res_out.run_final;
  assign track_status = res_out.track_status;
  assign pulse_total = res_out.pulse_total;
  assign overflow_error = res_out.overflow_error;

endmodule
`default_nettype wire

// File: rtl/hfe_c2f_fifo.sv
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps
`default_nettype none
module hfe_c2f_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full = (fill == FULL_CNT);
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/hfe_c2f_front.sv
// Front end: decodes track bytes and opcodes into cell run commands.
`timescale 1ns / 1ps
`default_nettype none
module hfe_c2f_front import hfe_c2f_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] cell_byte,
  input  wire logic       track_last,
  input  wire logic [7:0] start_cell_ticks,
  input  wire logic       v3_mode,
  output logic            cmd_push,
  output cmd_t            cmd
);

  typedef enum logic [1:0] {
    W_NONE,
    W_RATE,
    W_SKIP,
    W_DATA
  } wait_t;

  wait_t       opcode_wait;
  wait_t       opcode_wait_next;
  logic [7:0]  cell_duration;
  logic [7:0]  cell_duration_next;
  logic [2:0]  skip_cells;
  logic [2:0]  skip_cells_next;
  logic [31:0] lcg_state;
  logic [31:0] lcg_stepped;
  logic        lcg_advance;
  logic [7:0]  rev;
  logic        run;
  logic [7:0]  run_data;
  logic [2:0]  run_first;

  assign rev = bit_rev8(cell_byte);
  assign lcg_stepped = lcg_state * LCG_MUL + LCG_ADD;

  always_comb begin
    opcode_wait_next = opcode_wait;
    cell_duration_next = cell_duration;
    skip_cells_next = skip_cells;
    lcg_advance = 1'b0;
    run = 1'b0;
    run_data = cell_byte;
    run_first = 3'd0;
    unique case (opcode_wait)
      W_RATE: begin
        cell_duration_next = rate_ticks(rev);
        opcode_wait_next = W_NONE;
      end
      W_SKIP: begin
        skip_cells_next = rev[2:0];
        opcode_wait_next = W_DATA;
      end
      W_DATA: begin
        run = 1'b1;
        run_first = skip_cells;
        skip_cells_next = 3'd0;
        opcode_wait_next = W_NONE;
      end
      W_NONE: begin
        if (v3_mode && cell_byte[3:0] == OPC_NIBBLE) begin
          unique case (cell_byte)
            OPC_BITRATE: opcode_wait_next = W_RATE;
            OPC_SKIPBITS: opcode_wait_next = W_SKIP;
            OPC_RAND: begin
              run = 1'b1;
              run_data = lcg_stepped[31:24];
              lcg_advance = 1'b1;
            end
            default: begin
            end
          endcase
        end else begin
          run = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (track_last) begin
      cell_duration_next = start_cell_ticks;
      opcode_wait_next = W_NONE;
      skip_cells_next = 3'd0;
    end
  end

  assign cmd_push = accept && (run || track_last);
  assign cmd.data = run_data;
  assign cmd.first = run_first;
  assign cmd.dur = cell_duration;
  assign cmd.run = run;
  assign cmd.last = track_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode_wait <= W_NONE;
      cell_duration <= START_TICKS_RST;
      skip_cells <= 3'd0;
      lcg_state <= LCG_SEED;
    end else if (accept) begin
      opcode_wait <= opcode_wait_next;
      cell_duration <= cell_duration_next;
      skip_cells <= skip_cells_next;
      if (lcg_advance) begin
        lcg_state <= lcg_stepped;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/hfe_c2f_back.sv
// Back end: walks bit cells, accumulates gaps and issues pulse and status results.
`timescale 1ns / 1ps
`default_nettype none
module hfe_c2f_back import hfe_c2f_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic [15:0] pulse_limit,
  output logic             res_push,
  output res_t             res_data,
  input  wire logic        res_full
);

  localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CELL,
    B_EMIT,
    B_STATUS,
    B_FLUSH
  } state_t;

  state_t                state;
  cmd_t                  cur;
  logic [2:0]            bit_idx;
  logic [13:0]           gap;
  logic [COUNT_BITS-1:0] pulse_count;
  logic                  error_flag;
  logic                  held_valid;
  res_t                  held;

  logic [14:0]   gap_sum;
  logic [13:0]   gap_sat;
  logic          cell_bit;
  logic [WIDE-1:0] count_x;
  logic          limit_hit;
  logic          cand_req;
  logic          cand_pulse;
  logic [7:0]    cand_gap;
  logic          cand_valid;
  res_t          cand;
  logic          flush;
  logic          want_push;
  logic          stall;
  logic          cell_done;

  assign count_x = WIDE'(pulse_count);
  assign gap_sum = {1'b0, gap} + {7'd0, cur.dur};
  assign gap_sat = (gap_sum > {1'b0, GAP_CAP}) ? GAP_CAP : gap_sum[13:0];
  assign cell_bit = cur.data[bit_idx];
  assign limit_hit = (count_x >= WIDE'(pulse_limit)) || (&pulse_count);

  always_comb begin
    cand_req = 1'b0;
    cand_pulse = 1'b1;
    cand_gap = 8'd0;
    cell_done = 1'b0;
    unique case (state)
      B_CELL: begin
        if (cell_bit && gap_sat <= CHUNK) begin
          cand_req = (gap_sat != 14'd0);
          cand_gap = gap_sat[7:0];
        end
        cell_done = !(cell_bit && gap_sat > CHUNK);
      end
      B_EMIT: begin
        if (gap > CHUNK) begin
          cand_req = 1'b1;
          cand_gap = CHUNK[7:0];
        end else begin
          cand_req = (gap != 14'd0);
          cand_gap = gap[7:0];
          cell_done = 1'b1;
        end
      end
      B_STATUS: begin
        cand_req = 1'b1;
        cand_pulse = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign cand_valid = cand_req && (!cand_pulse || !limit_hit);
  assign cand.pulse_gap = cand_gap;
  assign cand.run_final = 1'b0;
  assign cand.track_status = !cand_pulse;
  assign cand.pulse_total = cand_pulse ? 16'd0 : count_x[15:0];
  assign cand.overflow_error = cand_pulse ? 1'b0 : error_flag;

  assign flush = (state == B_FLUSH) && held_valid;
  assign want_push = (cand_valid && held_valid) || flush;
  assign stall = want_push && res_full;
  assign res_push = want_push && !res_full;
  always_comb begin
    res_data = held;
    res_data.run_final = flush;
  end

  assign cmd_pop = (state == B_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      bit_idx <= 3'd0;
      gap <= 14'd0;
      pulse_count <= '0;
      error_flag <= 1'b0;
      held_valid <= 1'b0;
    end else if (!stall) begin
      if (cand_valid) begin
        held <= cand;
        held_valid <= 1'b1;
      end else if (flush) begin
        held_valid <= 1'b0;
      end
      if (cand_valid && cand_pulse) begin
        pulse_count <= pulse_count + 1'b1;
      end
      if (cand_req && cand_pulse && limit_hit) begin
        error_flag <= 1'b1;
      end
      unique case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            bit_idx <= cmd.first;
            state <= cmd.run ? B_CELL : B_STATUS;
          end
        end
        B_CELL, B_EMIT: begin
          if (state == B_CELL) begin
            gap <= (cell_bit && gap_sat <= CHUNK) ? 14'd0 : gap_sat;
          end else begin
            gap <= (gap > CHUNK) ? gap - CHUNK : 14'd0;
          end
          if (cell_done) begin
            if (bit_idx == 3'd7) begin
              state <= cur.last ? B_STATUS : B_FLUSH;
            end else begin
              bit_idx <= bit_idx + 3'd1;
              state <= B_CELL;
            end
          end else begin
            state <= B_EMIT;
          end
        end
        B_STATUS: begin
          gap <= 14'd0;
          pulse_count <= '0;
          error_flag <= 1'b0;
          state <= B_FLUSH;
        end
        B_FLUSH: begin
          state <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_idle_nothing_held: assert property (@(posedge clk) disable iff (rst)
    state == B_IDLE |-> !held_valid)
    else $error("result still held while waiting for a command");

  a_gap_capped: assert property (@(posedge clk) disable iff (rst)
    gap <= GAP_CAP)
    else $error("gap counter above saturation value");

  a_emit_has_gap: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> gap != 14'd0)
    else $error("chunk emission entered without a gap to split");

  a_push_from_held: assert property (@(posedge clk) disable iff (rst)
    res_push |=> held_valid || state == B_IDLE)
    else $error("result pushed without a replacement or end of request");

endmodule
`default_nettype wire

// File: tb/hfe_c2f_checker.sv
// Checker that predicts and compares every result of the cell stream to flux gap converter.
`timescale 1ns / 1ps
module hfe_c2f_checker import hfe_c2f_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic                  full,
  input  wire logic [7:0]            cell_byte,
  input  wire logic                  track_last,
  input  wire logic                  empty,
  input  wire logic                  pop,
  input  wire logic [7:0]            pulse_gap,
  input  wire logic                  run_final,
  input  wire logic                  track_status,
  input  wire logic [15:0]           pulse_total,
  input  wire logic                  overflow_error,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);

  typedef enum logic [1:0] {ARG_NONE, ARG_RATE, ARG_SKIP, SKIPPED_DATA} arg_wait_e;

  logic [7:0]  start_ticks;
  logic        v3_on;
  logic [15:0] limit;
  logic [7:0]  cell_len;
  logic [13:0] gap;
  arg_wait_e   arg_wait;
  logic [2:0]  skip_n;
  logic [31:0] lcg;
  logic [15:0] count;
  logic        err_seen;
  res_t        due_results[$];
  res_t        step_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [7:0] mirror_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[i];
    return r;
  endfunction

  task automatic put_pulse(input int value);
    res_t r;
    if (count >= limit || count == 16'hffff) begin
      err_seen = 1'b1;
    end else begin
      r = '0;
      r.pulse_gap = value[7:0];
      step_results.push_back(r);
      count++;
    end
  endtask

  task automatic walk_cells(input logic [7:0] b, input int first);
    int g;
    for (int i = first; i < 8; i++) begin
      g = int'(gap) + int'(cell_len);
      if (g > int'(GAP_CAP)) g = int'(GAP_CAP);
      if (b[i]) begin
        while (g > int'(CHUNK)) begin
          put_pulse(int'(CHUNK));
          g -= int'(CHUNK);
        end
        if (g > 0) put_pulse(g);
        g = 0;
      end
      gap = g[13:0];
    end
  endtask

  task automatic new_track();
    cell_len = start_ticks;
    gap = '0;
    arg_wait = ARG_NONE;
    skip_n = '0;
    count = '0;
    err_seen = 1'b0;
  endtask

  task automatic convert_byte(input logic [7:0] b, input logic last);
    res_t r;
    int quot;
    logic [7:0] m;
    step_results.delete();
    case (arg_wait)
      ARG_RATE: begin
        quot = (2 * int'(mirror_bits(b))) / 3;
        cell_len = (quot == 0) ? 8'd1 : quot[7:0];
        arg_wait = ARG_NONE;
      end
      ARG_SKIP: begin
        m = mirror_bits(b);
        skip_n = m[2:0];
        arg_wait = SKIPPED_DATA;
      end
      SKIPPED_DATA: begin
        walk_cells(b, int'(skip_n));
        skip_n = '0;
        arg_wait = ARG_NONE;
      end
      default: begin
        if (v3_on && b[3:0] == OPC_NIBBLE) begin
          if (b == OPC_BITRATE) begin
            arg_wait = ARG_RATE;
          end else if (b == OPC_SKIPBITS) begin
            arg_wait = ARG_SKIP;
          end else if (b == OPC_RAND) begin
            lcg = lcg * LCG_MUL + LCG_ADD;
            walk_cells(lcg[31:24], 0);
          end
        end else begin
          walk_cells(b, 0);
        end
      end
    endcase
    if (last) begin
      r = '0;
      r.track_status = 1'b1;
      r.pulse_total = count;
      r.overflow_error = err_seen;
      step_results.push_back(r);
      new_track();
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.run_final = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) due_results.push_back(step_results[i]);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      start_ticks = START_TICKS_RST;
      v3_on = 1'b0;
      limit = PULSE_LIMIT_RST;
      lcg = LCG_SEED;
      new_track();
      due_results.delete();
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report("result with nothing expected, pulse_gap", {8'd0, pulse_gap}, 16'd0);
        end else begin
          want = due_results.pop_front();
          if (pulse_gap !== want.pulse_gap)
            report("pulse_gap", {8'd0, pulse_gap}, {8'd0, want.pulse_gap});
          if (run_final !== want.run_final)
            report("run_final", {15'd0, run_final}, {15'd0, want.run_final});
          if (track_status !== want.track_status)
            report("track_status", {15'd0, track_status}, {15'd0, want.track_status});
          if (pulse_total !== want.pulse_total)
            report("pulse_total", pulse_total, want.pulse_total);
          if (overflow_error !== want.overflow_error)
            report("overflow_error", {15'd0, overflow_error}, {15'd0, want.overflow_error});
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_CELL_TICKS: start_ticks = cfg_data[7:0];
          REG_V3_MODE:          v3_on = cfg_data[0];
          REG_PULSE_LIMIT:      limit = cfg_data[15:0];
          default: ;
        endcase
      end
      if (push && !full) convert_byte(cell_byte, track_last);
    end
    pending <= due_results.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the testbench: clock, reset, request stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import hfe_c2f_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 58;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic [7:0]            cell_byte = 8'd0;
  logic                  track_last = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  full;
  logic                  empty;
  logic [7:0]            pulse_gap;
  logic                  run_final;
  logic                  track_status;
  logic [15:0]           pulse_total;
  logic                  overflow_error;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct = 0;
  int                    pop_stall_pct = 0;
  int                    hold_left = 0;
  int                    sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  hfe_cell_stream_to_flux_gaps uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cell_byte(cell_byte),
    .track_last(track_last), .empty(empty), .pop(pop), .pulse_gap(pulse_gap),
    .run_final(run_final), .track_status(track_status), .pulse_total(pulse_total),
    .overflow_error(overflow_error), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  hfe_c2f_checker flux_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .cell_byte(cell_byte),
    .track_last(track_last), .empty(empty), .pop(pop), .pulse_gap(pulse_gap),
    .run_final(run_final), .track_status(track_status), .pulse_total(pulse_total),
    .overflow_error(overflow_error), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  // The receiver either holds off for a counted stretch or stalls at random.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cell_byte <= b;
    track_last <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // A new start duration only applies from the next track, so a one-byte track follows.
  task automatic configure(input logic [7:0] start, input logic v3, input logic [15:0] lim);
    settle();
    set_reg(REG_START_CELL_TICKS, {8'd0, start});
    set_reg(REG_V3_MODE, {15'd0, v3});
    set_reg(REG_PULSE_LIMIT, lim);
    set_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_byte(8'h00, 1'b1);
  endtask

  task automatic send_track();
    logic [7:0] seq[$];
    int len;
    int pick;
    len = $urandom_range(1, 12);
    while (seq.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        case ($urandom_range(3))
          0: seq.push_back(8'h00);
          1: seq.push_back(8'h01 << $urandom_range(7));
          default: seq.push_back(8'($urandom));
        endcase
      end else if (pick < 58) begin
        seq.push_back(OPC_BITRATE);
        seq.push_back(8'($urandom));
      end else if (pick < 66) begin
        seq.push_back(OPC_SKIPBITS);
        seq.push_back(8'($urandom));
        seq.push_back(8'($urandom));
      end else if (pick < 74) begin
        seq.push_back(OPC_RAND);
      end else if (pick < 80) begin
        case ($urandom_range(2))
          0: seq.push_back(OPC_NOP);
          1: seq.push_back(OPC_INDEX);
          default: seq.push_back({4'($urandom), OPC_NIBBLE});
        endcase
      end else begin
        seq.push_back(8'($urandom));
      end
    end
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  initial begin
    logic [7:0]  start;
    logic [15:0] lim;
    int          phase_end;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: opcode bytes pass through as plain data.
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(OPC_BITRATE, 1'b0);
    send_byte(OPC_SKIPBITS, 1'b1);

    // Longest cells: the gap saturates and is split into full chunks.
    configure(8'd255, 1'b1, 16'hffff);
    repeat (5) send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(OPC_NOP, 1'b0);
    send_byte(OPC_INDEX, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(OPC_RAND, 1'b0);
    send_byte(OPC_BITRATE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(OPC_BITRATE, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(OPC_SKIPBITS, 1'b0);
    send_byte(8'he0, 1'b0);
    send_byte(OPC_SKIPBITS, 1'b0);
    send_byte(OPC_SKIPBITS, 1'b0);
    send_byte(8'h4f, 1'b1);

    // A waiting bitrate argument is still taken after opcode handling is switched off.
    send_byte(OPC_BITRATE, 1'b0);
    settle();
    set_reg(REG_V3_MODE, '0);
    cfg_we <= 1'b0;
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(3))
        0: start = 8'd1;
        1: start = 8'd255;
        default: start = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(4))
        0: lim = 16'd0;
        1: lim = 16'($urandom_range(1, 40));
        default: lim = 16'hffff;
      endcase
      configure(start, $urandom_range(3) != 0, lim);
      case (ph)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
          hold_left = HOLD_CYCLES;
        end
        1: begin
          send_idle_pct = 75;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 14;
          pop_stall_pct = 14;
        end
      endcase
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) send_track();
    end

    pop_stall_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hfe_c2f_pkg.sv
rtl/hfe_c2f_fifo.sv
rtl/hfe_c2f_front.sv
rtl/hfe_c2f_back.sv
rtl/hfe_cell_stream_to_flux_gaps.sv
tb/hfe_c2f_checker.sv
tb/tb_top.sv
